>>> hdl/ttq_pkg.sv
// Shared types and constants of the timed task queue.
// Used by ttq_ctrl, ttq_dp and timed_task_queue; depends on nothing.
package ttq_pkg;

    // Request codes on the input channel
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SCHED    = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_SET_TIME = 2'd3
    } t_cmd;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_SCHEDULED = 3'd1,
        KIND_REMOVED   = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_TIME_SET  = 3'd5
    } t_kind;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_FIN,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_REM_RD,
        S_REM_CHK,
        S_SHF_RD,
        S_SHF_WR,
        S_EMIT
    } t_state;

    // Which queue slot, relative to the walk index, a read targets
    typedef enum logic [1:0] {
        ASEL_IDX,
        ASEL_IDX_M1,
        ASEL_IDX_P1
    } t_addr_sel;

    localparam logic [4:0]  MAX_FIRE    = 5'd16;
    localparam logic [15:0] MIN_LOW     = 16'd2;
    localparam logic [31:0] DUE_BUMP    = 32'd4;
    localparam logic [7:0]  MARGIN_INIT = 8'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic      accept;
        logic      decode;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      wr_en;
        logic      wr_new;
        logic      idx_dec;
        logic      idx_inc;
        logic      pop;
        logic      count_inc;
        logic      count_dec;
        logic      take_fire;
        logic      pend_clr;
        logic      keep_rd_due;
        logic      out_load;
        t_kind     out_kind;
        logic      out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic count_zero;
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic idx_next_at_count;
        logic ins_shift;
        logic fire_hit;
        logic tag_hit;
        logic slot_free;
        logic pend;
        logic fire_more;
    } t_dp_stat;

endpackage

>>> hdl/timed_task_queue.sv
// Timed task queue: 32-bit millisecond clock and a due-time sorted queue.
// Top level; instantiates ttq_ctrl and ttq_dp, depends on ttq_pkg.
//
// Requests enter on i_in_valid/o_in_ready with i_cmd, i_delay, i_tag and
// i_time_low. Results leave on o_out_valid/i_out_ready; a tick gives zero to
// sixteen fired results, every other request exactly one. o_last marks the
// final result of a request. fire_margin is written on i_cfg_valid/o_cfg_ready
// (ready whenever out of reset); the user must write it only while the block
// is idle, which the block itself does not enforce. One request is handled
// at a time. Set time and a schedule into a full queue go straight to the
// result register. A tick reads tasks from the head, one per step, and fires
// them while each is due by now plus fire_margin; on an empty queue it ends
// with no result. A schedule walks down from the tail, moving each queued
// task at or after the new due time up one slot, then writes the new task.
// A remove reads from the head until the tag matches or the queue ends, then
// shifts the later tasks down one slot. Each step reads one slot of the task
// store, with a registered read.
// Reset clears the time, empties the queue and sets fire_margin to 2; no
// clearing pass is needed. The result register lets the block finish or take
// a new request while a result waits; when the receiver stalls, the block
// holds at the point where it next needs the register.
module timed_task_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_delay,
    input  logic [15:0] i_tag,
    input  logic [15:0] i_time_low,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_fire_margin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_task_tag,
    output logic [31:0] o_due_time,
    output logic [4:0]  o_queue_count,
    output logic        o_last
);
    import ttq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = i_rst_n;

    // Sequencer
    ttq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath
    ttq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_req_cmd         (i_cmd),
        .i_delay           (i_delay),
        .i_tag             (i_tag),
        .i_time_low        (i_time_low),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_fire_margin (i_cfg_fire_margin),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_task_tag        (o_task_tag),
        .o_due_time        (o_due_time),
        .o_queue_count     (o_queue_count),
        .o_last            (o_last)
    );

endmodule

>>> hdl/ttq_ctrl.sv
// Sequencer of the timed task queue: walks the queue one slot per step.
// Depends on ttq_pkg; drives ttq_dp through t_dp_cmd.
module ttq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ttq_pkg::t_dp_stat i_stat,
    output ttq_pkg::t_dp_cmd  o_cmd
);
    import ttq_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_FIRED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_TICK: n_state = i_stat.count_zero ? S_IDLE : S_TICK_RD;
                    CMD_SCHED: begin
                        if (i_stat.full) begin
                            n_state = S_EMIT;
                            n_kind  = KIND_FULL;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    CMD_REMOVE: n_state = S_REM_RD;
                    CMD_SET_TIME: begin
                        n_state = S_EMIT;
                        n_kind  = KIND_TIME_SET;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TICK_RD: n_state = S_TICK_CHK;
            S_TICK_CHK: begin
                if (!i_stat.fire_hit) begin
                    n_state = S_TICK_FIN;
                end else if (!i_stat.pend || i_stat.slot_free) begin
                    n_state = i_stat.fire_more ? S_TICK_RD : S_TICK_FIN;
                end
            end
            S_TICK_FIN: begin
                if (!i_stat.pend || i_stat.slot_free) n_state = S_IDLE;
            end
            S_INS_RD: n_state = i_stat.idx_zero ? S_INS_PUT : S_INS_CHK;
            S_INS_CHK: n_state = i_stat.ins_shift ? S_INS_RD : S_INS_PUT;
            S_INS_PUT: begin
                n_state = S_EMIT;
                n_kind  = KIND_SCHEDULED;
            end
            S_REM_RD: begin
                if (i_stat.idx_at_count) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_NOT_FOUND;
                end else begin
                    n_state = S_REM_CHK;
                end
            end
            S_REM_CHK: n_state = i_stat.tag_hit ? S_SHF_RD : S_REM_RD;
            S_SHF_RD: begin
                if (i_stat.idx_next_at_count) begin
                    n_state = S_EMIT;
                    n_kind  = KIND_REMOVED;
                end else begin
                    n_state = S_SHF_WR;
                end
            end
            S_SHF_WR: n_state = S_SHF_RD;
            S_EMIT: begin
                if (i_stat.slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = ASEL_IDX;
        o_cmd.out_kind = KIND_FIRED;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            S_DECODE: o_cmd.decode = 1'b1;
            S_TICK_RD: o_cmd.rd_en = 1'b1;
            S_TICK_CHK: begin
                if (i_stat.fire_hit && (!i_stat.pend || i_stat.slot_free)) begin
                    o_cmd.out_load  = i_stat.pend;
                    o_cmd.take_fire = 1'b1;
                    o_cmd.pop       = 1'b1;
                end
            end
            S_TICK_FIN: begin
                if (i_stat.pend && i_stat.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                end
            end
            S_INS_RD: begin
                o_cmd.rd_en  = !i_stat.idx_zero;
                o_cmd.rd_sel = ASEL_IDX_M1;
            end
            S_INS_CHK: begin
                o_cmd.wr_en   = i_stat.ins_shift;
                o_cmd.idx_dec = i_stat.ins_shift;
            end
            S_INS_PUT: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_new    = 1'b1;
                o_cmd.count_inc = 1'b1;
            end
            S_REM_RD: o_cmd.rd_en = !i_stat.idx_at_count;
            S_REM_CHK: begin
                o_cmd.keep_rd_due = i_stat.tag_hit;
                o_cmd.idx_inc     = !i_stat.tag_hit;
            end
            S_SHF_RD: begin
                o_cmd.count_dec = i_stat.idx_next_at_count;
                o_cmd.rd_en     = !i_stat.idx_next_at_count;
                o_cmd.rd_sel    = ASEL_IDX_P1;
            end
            S_SHF_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            S_EMIT: begin
                o_cmd.out_load = i_stat.slot_free;
                o_cmd.out_kind = r_kind;
                o_cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/ttq_dp.sv
// Datapath of the timed task queue: time counter, circular task store,
// walk index, pending fire register and result register. Depends on ttq_pkg.
module ttq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttq_pkg::t_dp_cmd  i_cmd,
    output ttq_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_req_cmd,
    input  logic [31:0]       i_delay,
    input  logic [15:0]       i_tag,
    input  logic [15:0]       i_time_low,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_fire_margin,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_kind,
    output logic [15:0]       o_task_tag,
    output logic [31:0]       o_due_time,
    output logic [4:0]        o_queue_count,
    output logic              o_last
);
    import ttq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_MAX = AW'(QUEUE_DEPTH - 1);

    // Task store
    logic [31:0] due_mem [QUEUE_DEPTH];
    logic [15:0] tag_mem [QUEUE_DEPTH];

    logic [31:0]   r_now, r_due, r_limit, r_rd_due, r_pend_due;
    logic [15:0]   r_tag, r_tlow, r_rd_tag, r_pend_tag;
    logic [7:0]    r_margin;
    t_cmd          r_cmd;
    logic [CW-1:0] r_count, r_idx;
    logic [AW-1:0] r_head;
    logic [4:0]    r_nfired;
    logic          r_pend;
    logic          r_out_valid;
    t_kind         r_out_kind;
    logic [15:0]   r_out_tag;
    logic [31:0]   r_out_due;
    logic [CW-1:0] r_out_count;
    logic          r_out_last;

    logic [CW-1:0] rd_ofs;
    logic [CW:0]   rd_sum, wr_sum;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          slot_free;
    logic [CW+4:0] cnt_ext;

    // Logical slot to physical address (head-relative, wraps once)
    always_comb begin
        unique case (i_cmd.rd_sel)
            ASEL_IDX_M1: rd_ofs = r_idx - CW'(1);
            ASEL_IDX_P1: rd_ofs = r_idx + CW'(1);
            default:     rd_ofs = r_idx;
        endcase
        rd_sum = (CW + 1)'(r_head) + (CW + 1)'(rd_ofs);
        wr_sum = (CW + 1)'(r_head) + (CW + 1)'(r_idx);
        if (rd_sum >= DEPTH_W) rd_sum = rd_sum - DEPTH_W;
        if (wr_sum >= DEPTH_W) wr_sum = wr_sum - DEPTH_W;
        rd_addr = rd_sum[AW-1:0];
        wr_addr = wr_sum[AW-1:0];
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            due_mem[wr_addr] <= i_cmd.wr_new ? r_due : r_rd_due;
            tag_mem[wr_addr] <= i_cmd.wr_new ? r_tag : r_rd_tag;
        end
        if (i_cmd.rd_en) begin
            r_rd_due <= due_mem[rd_addr];
            r_rd_tag <= tag_mem[rd_addr];
        end
    end

    // Request latch and decode arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= t_cmd'(i_req_cmd);
            r_tag  <= i_tag;
            r_tlow <= i_time_low;
            r_due  <= i_delay + r_now;
        end else if (i_cmd.decode) begin
            r_limit <= r_now + 32'(r_margin);
            if (r_due[15:0] < MIN_LOW) r_due <= r_due + DUE_BUMP;
        end else if (i_cmd.keep_rd_due) begin
            r_due <= r_rd_due;
        end
        if (i_cmd.take_fire) begin
            r_pend_due <= r_rd_due;
            r_pend_tag <= r_rd_tag;
        end
    end

    // Control state: time, margin, queue pointers, walk index, fire count, pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_margin <= MARGIN_INIT;
            r_count  <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_nfired <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_margin <= i_cfg_fire_margin;
            if (i_cmd.accept && t_cmd'(i_req_cmd) == CMD_TICK) r_now <= r_now + 32'd1;
            if (i_cmd.decode && r_cmd == CMD_SET_TIME) r_now <= {r_now[31:16], r_tlow};
            if (i_cmd.accept) begin
                r_idx    <= '0;
                r_nfired <= '0;
            end else if (i_cmd.decode && r_cmd == CMD_SCHED) begin
                r_idx <= r_count;
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.pop) begin
                r_head   <= (r_head == HEAD_MAX) ? '0 : r_head + AW'(1);
                r_count  <= r_count - CW'(1);
                r_nfired <= r_nfired + 5'd1;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.take_fire) r_pend <= 1'b1;
            else if (i_cmd.pend_clr) r_pend <= 1'b0;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind  <= i_cmd.out_kind;
            r_out_last  <= i_cmd.out_last;
            r_out_count <= r_count;
            unique case (i_cmd.out_kind)
                KIND_FIRED: begin
                    r_out_tag <= r_pend_tag;
                    r_out_due <= r_pend_due;
                end
                KIND_NOT_FOUND: begin
                    r_out_tag <= r_tag;
                    r_out_due <= '0;
                end
                KIND_TIME_SET: begin
                    r_out_tag <= '0;
                    r_out_due <= r_now;
                end
                default: begin
                    r_out_tag <= r_tag;
                    r_out_due <= r_due;
                end
            endcase
        end
    end

    // Status to the sequencer
    always_comb begin
        o_stat.cmd               = r_cmd;
        o_stat.count_zero        = (r_count == '0);
        o_stat.full              = (r_count >= DEPTH_C);
        o_stat.idx_zero          = (r_idx == '0);
        o_stat.idx_at_count      = (r_idx == r_count);
        o_stat.idx_next_at_count = ((r_idx + CW'(1)) == r_count);
        o_stat.ins_shift         = (r_rd_due >= r_due);
        o_stat.fire_hit          = (r_rd_due <= r_limit);
        o_stat.tag_hit           = (r_rd_tag == r_tag);
        o_stat.slot_free         = slot_free;
        o_stat.pend              = r_pend;
        o_stat.fire_more         = (r_count > CW'(1)) && (r_nfired < MAX_FIRE - 5'd1);
    end

    assign cnt_ext       = (CW + 5)'(r_out_count);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_task_tag    = r_out_tag;
    assign o_due_time    = r_out_due;
    assign o_queue_count = cnt_ext[4:0];
    assign o_last        = r_out_last;

endmodule

>>> sim/timed_task_queue_tb.sv
// Self-checking testbench of timed_task_queue: directed table, then random requests.
// Depends on ttq_pkg and the timed_task_queue RTL; results are checked against a local predictor.
module timed_task_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ttq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int FIRE_MAX  = 16;
    localparam int SETTLE    = 40;
    localparam int STALL_MAX = 5000;

    typedef struct {
        t_kind       kind;
        logic [15:0] tag;
        logic [31:0] due;
        logic [4:0]  cnt;
        logic        last;
    } t_result;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] delay;
        logic [15:0] tag;
        logic [15:0] tlow;
        bit          typed;
        t_result     want;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_delay;
    logic [15:0] i_tag;
    logic [15:0] i_time_low;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_fire_margin;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_kind;
    logic [15:0] o_task_tag;
    logic [31:0] o_due_time;
    logic [4:0]  o_queue_count;
    logic        o_last;

    timed_task_queue #(.QUEUE_DEPTH(DEPTH)) uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: time, margin and the sorted task list
    logic [31:0] now_ms;
    logic [7:0]  margin;
    logic [31:0] task_due [DEPTH];
    logic [15:0] task_tag [DEPTH];
    int          task_cnt;

    t_result     pending_results [$];
    t_req        table_rows [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    function automatic t_result mk_res(t_kind k, logic [15:0] tg, logic [31:0] d,
                                       int c, logic l);
        t_result r;
        r.kind = k; r.tag = tg; r.due = d; r.cnt = c[4:0]; r.last = l;
        return r;
    endfunction

    function automatic void report_diff(string where, t_result w, t_result g);
        if (w.kind !== g.kind || w.tag !== g.tag || w.due !== g.due ||
            w.cnt !== g.cnt || w.last !== g.last) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch %s: exp kind %0d tag %h due %h cnt %0d last %0b, ",
                          "got kind %0d tag %h due %h cnt %0d last %0b"},
                         where, w.kind, w.tag, w.due, w.cnt, w.last,
                         g.kind, g.tag, g.due, g.cnt, g.last);
        end
    endfunction

    function automatic void pop_task(int pos);
        for (int i = pos; i + 1 < task_cnt; i++) begin
            task_due[i] = task_due[i + 1];
            task_tag[i] = task_tag[i + 1];
        end
        task_cnt--;
    endfunction

    // compute the results one request causes and queue them
    function automatic void predict_results(t_req rq);
        logic [31:0] lim;
        logic [31:0] due;
        logic [15:0] tg;
        int          n;
        int          pos;
        bit          more;
        case (rq.cmd)
            CMD_TICK: begin
                now_ms = now_ms + 32'd1;
                lim = now_ms + {24'd0, margin};
                n = 0;
                while (task_cnt > 0 && n < FIRE_MAX && task_due[0] <= lim) begin
                    due = task_due[0];
                    tg = task_tag[0];
                    pop_task(0);
                    n++;
                    more = task_cnt > 0 && n < FIRE_MAX && task_due[0] <= lim;
                    pending_results.push_back(mk_res(KIND_FIRED, tg, due, task_cnt, !more));
                end
            end
            CMD_SCHED: begin
                due = rq.delay + now_ms;
                if (due[15:0] < 16'd2) due = due + 32'd4;
                if (task_cnt >= DEPTH) begin
                    pending_results.push_back(mk_res(KIND_FULL, rq.tag, due, task_cnt, 1'b1));
                end else begin
                    pos = 0;
                    while (pos < task_cnt && due > task_due[pos]) pos++;
                    for (int i = task_cnt; i > pos; i--) begin
                        task_due[i] = task_due[i - 1];
                        task_tag[i] = task_tag[i - 1];
                    end
                    task_due[pos] = due;
                    task_tag[pos] = rq.tag;
                    task_cnt++;
                    pending_results.push_back(mk_res(KIND_SCHEDULED, rq.tag, due, task_cnt, 1'b1));
                end
            end
            CMD_REMOVE: begin
                pos = -1;
                for (int i = 0; i < task_cnt; i++)
                    if (pos < 0 && task_tag[i] == rq.tag) pos = i;
                if (pos >= 0) begin
                    due = task_due[pos];
                    pop_task(pos);
                    pending_results.push_back(mk_res(KIND_REMOVED, rq.tag, due, task_cnt, 1'b1));
                end else begin
                    pending_results.push_back(mk_res(KIND_NOT_FOUND, rq.tag, 32'd0, task_cnt, 1'b1));
                end
            end
            default: begin
                now_ms = {now_ms[31:16], rq.tlow};
                pending_results.push_back(mk_res(KIND_TIME_SET, 16'd0, now_ms, task_cnt, 1'b1));
            end
        endcase
    endfunction

    function automatic void add_row(t_cmd c, logic [31:0] d, logic [15:0] tg,
                                    logic [15:0] tl);
        t_req rq;
        rq.cmd = c; rq.delay = d; rq.tag = tg; rq.tlow = tl; rq.typed = 0;
        table_rows.push_back(rq);
    endfunction

    function automatic void add_typed(t_cmd c, logic [31:0] d, logic [15:0] tg,
                                      logic [15:0] tl, t_result w);
        t_req rq;
        rq.cmd = c; rq.delay = d; rq.tag = tg; rq.tlow = tl;
        rq.typed = 1; rq.want = w;
        table_rows.push_back(rq);
    endfunction

    // random request, mostly well-formed: known tags, small delays, low-bit bump hits
    function automatic t_req rand_req();
        t_req rq;
        int   sel;
        int   pick;
        rq.typed = 0;
        rq.tlow  = 16'($urandom);
        rq.tag   = ($urandom_range(99) < 20) ? 16'($urandom) : 16'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 70)      rq.delay = $urandom_range(40);
        else if (pick < 80) rq.delay = {16'($urandom_range(3)), 16'h0} - now_ms +
                                       $urandom_range(1);
        else                rq.delay = $urandom;
        sel = $urandom_range(99);
        if (sel < 35)      rq.cmd = CMD_TICK;
        else if (sel < 72) rq.cmd = CMD_SCHED;
        else if (sel < 92) begin
            rq.cmd = CMD_REMOVE;
            if (task_cnt > 0 && $urandom_range(99) < 70)
                rq.tag = task_tag[$urandom_range(task_cnt - 1)];
        end else           rq.cmd = CMD_SET_TIME;
        return rq;
    endfunction

    task automatic send_req(t_req rq);
        int sz;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= rq.cmd;
        i_delay    <= rq.delay;
        i_tag      <= rq.tag;
        i_time_low <= rq.tlow;
        // ready is settled at the falling edge and holds until the next rising one
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        sz = pending_results.size();
        predict_results(rq);
        if (rq.typed) report_diff("table", rq.want, pending_results[sz]);
    endtask

    // wait for every expected result, then let a possibly silent tick finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [7:0] m);
        i_cfg_valid       <= 1'b1;
        i_cfg_fire_margin <= m;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        margin = m;
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stalls
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind = t_kind'(o_kind);
            got.tag = o_task_tag; got.due = o_due_time;
            got.cnt = o_queue_count; got.last = o_last;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind %0d tag %h due %h",
                             o_kind, o_task_tag, o_due_time);
            end else begin
                report_diff("result", pending_results.pop_front(), got);
            end
        end
    end

    // watchdog on cycles with no request, result or margin write moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX) begin
            $display("FAIL timed_task_queue");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_cmd             <= CMD_TICK;
        i_delay           <= '0;
        i_tag             <= '0;
        i_time_low        <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_fire_margin <= '0;
        now_ms = '0; margin = MARGIN_INIT; task_cnt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, field extremes, bump, equal due, not found
        add_typed(CMD_SET_TIME, 32'd0, 16'hFFFF, 16'hFFFF,
                  mk_res(KIND_TIME_SET, 16'h0, 32'h0000FFFF, 0, 1'b1));
        add_typed(CMD_SCHED, 32'd0, 16'hFFFF, 16'h0,
                  mk_res(KIND_SCHEDULED, 16'hFFFF, 32'h0000FFFF, 1, 1'b1));
        add_typed(CMD_SCHED, 32'd1, 16'h0001, 16'h0,
                  mk_res(KIND_SCHEDULED, 16'h0001, 32'h00010004, 2, 1'b1));
        add_typed(CMD_SCHED, 32'hFFFFFFFF, 16'h0002, 16'h0,
                  mk_res(KIND_SCHEDULED, 16'h0002, 32'h0000FFFE, 3, 1'b1));
        add_typed(CMD_REMOVE, 32'd0, 16'h1234, 16'h0,
                  mk_res(KIND_NOT_FOUND, 16'h1234, 32'd0, 3, 1'b1));
        add_typed(CMD_REMOVE, 32'd0, 16'h0002, 16'h0,
                  mk_res(KIND_REMOVED, 16'h0002, 32'h0000FFFE, 2, 1'b1));
        add_row(CMD_TICK, 32'd0, 16'h0, 16'h0);
        add_row(CMD_SET_TIME, 32'd0, 16'h0, 16'h0000);
        add_row(CMD_TICK, 32'd0, 16'h0, 16'h0);   // nothing due
        add_row(CMD_SCHED, 32'd3, 16'h0005, 16'h0); // equal due goes first
        add_row(CMD_REMOVE, 32'd0, 16'h0001, 16'h0);
        foreach (table_rows[i]) send_req(table_rows[i]);
        drain();

        // fill past full at margin 0, then a wide margin fires the lot
        write_margin(8'd0);
        table_rows.delete();
        for (int i = 0; i < DEPTH + 1; i++)
            add_row(CMD_SCHED, 32'(i), 16'(16'h0100 + i), 16'h0);
        add_row(CMD_TICK, 32'd0, 16'h0, 16'h0);
        foreach (table_rows[i]) send_req(table_rows[i]);
        drain();
        write_margin(8'd255);
        table_rows.delete();
        add_row(CMD_TICK, 32'd0, 16'h0, 16'h0);
        add_row(CMD_TICK, 32'd0, 16'h0, 16'h0);
        foreach (table_rows[i]) send_req(table_rows[i]);
        drain();

        // random phases under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 7 : 0;
            for (int half = 0; half < 2; half++) begin
                write_margin((ph == 2 && half == 0) ? 8'd0 : 8'($urandom_range(255)));
                repeat (75) send_req(rand_req());
                drain();
            end
        end

        if (errors == 0)
            $display("PASS timed_task_queue");
        else
            $display("FAIL timed_task_queue");
        $finish;
    end
endmodule
